// ===== sv/sasl2_pkg.sv =====
// ----------------------------------------------------------------------------
// sasl2_pkg
// Types, constants and helper functions of the sas l2 authentication engine.
// ----------------------------------------------------------------------------
package sasl2_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned DIGITS   = 10;
	localparam int unsigned BCD_W    = 4 * DIGITS;
	localparam int unsigned CONV_CYC = WORD_W / 2;

	localparam logic [WORD_W-1:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
	localparam logic [3:0]        ASCII_HI  = 4'h3;

	typedef enum logic [1:0] {
		KIND_REG  = 2'd0,
		KIND_CHAL = 2'd1,
		KIND_RESP = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_NO_ROUND = 2'd2,
		STAT_UNUSED   = 2'd3
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_HASH = 5'b00100,
		ST_CALC = 5'b01000,
		ST_SPARE = 5'b10000
	} state_t;

	// one reflected crc-32 byte step
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
			input logic [7:0] data);
		logic [WORD_W-1:0] c;
		c = crc ^ {24'h0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// one shift-and-add-3 step of binary to bcd conversion
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
			input logic bit_in);
		logic [BCD_W-1:0] t;
		t = bcd;
		for (int d = 0; d < DIGITS; d++) begin
			if (t[4*d +: 4] >= 4'd5) begin
				t[4*d +: 4] = t[4*d +: 4] + 4'd3;
			end
		end
		return {t[BCD_W-2:0], bit_in};
	endfunction

	// addition modulo 2^32-1 as the protocol defines it
	function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W] ? (s[WORD_W-1:0] + 32'd1) : s[WORD_W-1:0];
	endfunction

endpackage

// ===== sv/sas_l2_auth_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sas_l2_auth_engine_unit
// Server side of a sas l2 style mutual authentication with a crc-32 hash.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_data write the 32-bit identity word; write it only while idle.
//   Input beats (in_valid/in_stall) carry kind, nonce and value; each beat
//   gives exactly one output beat (out_valid/out_stall) with status,
//   first_word and second_word.
//   Register and challenge beats convert identity^nonce to decimal two bits a
//   cycle in the shift-and-add-3 converter, then hash the digits one crc
//   byte step a cycle, then a final update step writes the protocol state
//   and the output register; the next beat is taken once that step is done.
//   Response and unused beats skip conversion and hashing and go straight
//   to the update step; a new beat waits until that step is done.
//   One item is in flight at a time; in_stall is high while it is worked on.
//   A new beat is taken while the previous result still waits in the output
//   register; the final update step waits until that register is free.
//   Reset clears identity, the stored and pending words, the open round flag
//   and the output register.
// ----------------------------------------------------------------------------
module sas_l2_auth_engine_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sasl2_pkg::WORD_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [sasl2_pkg::WORD_W-1:0] nonce,
	input  logic [sasl2_pkg::WORD_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [sasl2_pkg::WORD_W-1:0] first_word,
	output logic [sasl2_pkg::WORD_W-1:0] second_word
);
	import sasl2_pkg::*;

	state_t              state_q;
	logic [3:0]          cnt_q;
	kind_t               kind_q;
	logic [WORD_W-1:0]   value_q;
	logic [WORD_W-1:0]   bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [WORD_W-1:0]   crc_q;
	logic                started_q;
	logic [WORD_W-1:0]   id_q;
	logic [WORD_W-1:0]   stored_a_q;
	logic [WORD_W-1:0]   stored_m_q;
	logic [WORD_W-1:0]   pend_a_q;
	logic [WORD_W-1:0]   pend_m_q;
	logic [WORD_W-1:0]   pend_beta_q;
	logic                open_q;
	logic                out_valid_q;
	stat_t               status_q;
	logic [WORD_W-1:0]   w1_q;
	logic [WORD_W-1:0]   w2_q;

	logic                in_fire;
	logic                calc_fire;
	logic [3:0]          digit;
	logic                take_digit;
	logic [WORD_W-1:0]   hash_a2;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign calc_fire   = (state_q == ST_CALC) && !(out_valid_q && out_stall);
	assign digit       = bcd_q[BCD_W-1 -: 4];
	// leading zeros are skipped, but the last digit always counts
	assign take_digit  = started_q || (digit != 4'd0) || (cnt_q == 4'd0);
	assign hash_a2     = crc_q ^ WORD_ONES;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign first_word  = w1_q;
	assign second_word = w2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
		end else if (cfg_we) begin
			id_q <= cfg_data;
		end
	end

	// sequencer and digit-serial datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q     <= '0;
						started_q <= 1'b0;
						if (kind_t'(kind) == KIND_REG || kind_t'(kind) == KIND_CHAL) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CONV: begin
					if (cnt_q == 4'(CONV_CYC - 1)) begin
						cnt_q   <= 4'(DIGITS - 1);
						state_q <= ST_HASH;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_HASH: begin
					started_q <= take_digit;
					if (cnt_q == 4'd0) begin
						state_q <= ST_CALC;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				ST_CALC: begin
					if (calc_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q  <= kind_t'(kind);
			value_q <= value;
			bin_q   <= id_q ^ nonce;
			bcd_q   <= '0;
			crc_q   <= WORD_ONES;
		end else if (state_q == ST_CONV) begin
			bcd_q <= dabble(dabble(bcd_q, bin_q[WORD_W-1]), bin_q[WORD_W-2]);
			bin_q <= {bin_q[WORD_W-3:0], 2'b00};
		end else if (state_q == ST_HASH) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
			if (take_digit) begin
				crc_q <= crc_byte(crc_q, {ASCII_HI, digit});
			end
		end
	end

	// protocol state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_a_q  <= '0;
			stored_m_q  <= '0;
			pend_a_q    <= '0;
			pend_m_q    <= '0;
			pend_beta_q <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			w1_q        <= '0;
			w2_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (calc_fire) begin
				out_valid_q <= 1'b1;
				status_q    <= STAT_OK;
				w1_q        <= '0;
				w2_q        <= '0;
				case (kind_q)
					KIND_REG: begin
						stored_a_q <= hash_a2;
						stored_m_q <= value_q;
						open_q     <= 1'b0;
						w1_q       <= hash_a2;
						w2_q       <= value_q;
					end
					KIND_CHAL: begin
						w1_q        <= stored_a_q ^ hash_a2 ^ stored_m_q;
						pend_a_q    <= hash_a2;
						pend_beta_q <= add_mod(stored_a_q, hash_a2);
						pend_m_q    <= add_mod(stored_a_q, stored_m_q);
						open_q      <= 1'b1;
					end
					KIND_RESP: begin
						if (!open_q) begin
							status_q <= STAT_NO_ROUND;
						end else if (value_q != pend_beta_q) begin
							status_q <= STAT_MISMATCH;
						end else begin
							w1_q       <= stored_a_q ^ pend_m_q;
							stored_a_q <= pend_a_q;
							stored_m_q <= pend_m_q;
							open_q     <= 1'b0;
						end
					end
					default: begin
						status_q <= STAT_OK;
					end
				endcase
			end
		end
	end

endmodule
